// ===== rtl/core/alignment_pair_divergence_defines.svh =====
// ---------------------------------------------------------------------------
// Alignment pair divergence: assertion macros
// Shared concurrent-assertion helpers for the divergence block.
// ---------------------------------------------------------------------------
`ifndef ALIGNMENT_PAIR_DIVERGENCE_DEFINES_SVH
`define ALIGNMENT_PAIR_DIVERGENCE_DEFINES_SVH

// same-cycle implication
`define APD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define APD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/apd_pkg.sv =====
// ---------------------------------------------------------------------------
// apd_pkg
// Types and constants shared by the alignment pair divergence block.
// ---------------------------------------------------------------------------
package apd_pkg;

   localparam int RESIDUE_W  = 8;
   localparam int WEIGHT_W   = 9;
   localparam int DIV_W      = 17;
   localparam int OUT_CNT_W  = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   // quotient bits produced by the divider, one per step
   localparam int QUOT_STEPS = 17;
   localparam int STEP_W     = 5;

   localparam logic [CSR_IDX_W-1:0] REG_GAP_SYMBOL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_GAP_WEIGHT = 1'b1;

   localparam logic [RESIDUE_W-1:0] GAP_SYMBOL_RST = 8'd45;
   localparam logic [WEIGHT_W-1:0]  GAP_WEIGHT_RST = 9'd205;
   localparam logic [WEIGHT_W-1:0]  WEIGHT_ONE     = 9'd256;
   localparam logic [DIV_W-1:0]     DIV_MAX        = 17'h10000;

   typedef struct packed {
      logic col_en;    // apply one column to the counters
      logic mul_en;    // register the weighted gap products
      logic sum_en;    // register numerator / denominator, arm divider
      logic div_step;  // one restoring division step
      logic out_load;  // load result register, clear running state
   } apd_cmd_type;

   typedef struct packed {
      logic div_last;  // current step is the final quotient bit
   } apd_sts_type;

endpackage

// ===== rtl/core/apd_req_if.sv =====
// ---------------------------------------------------------------------------
// apd_req_if
// Column channel: two residues and the last-column marker per beat.
// ---------------------------------------------------------------------------
interface apd_req_if;
   import apd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [RESIDUE_W-1:0] residue_a;
   logic [RESIDUE_W-1:0] residue_b;
   logic                 last_column;

   modport source (output valid, output residue_a, output residue_b,
                   output last_column, input ready);
   modport sink   (input valid, input residue_a, input residue_b,
                   input last_column, output ready);
endinterface

// ===== rtl/core/apd_rsp_if.sv =====
// ---------------------------------------------------------------------------
// apd_rsp_if
// Result channel: divergence, the four counts and the empty flag per beat.
// ---------------------------------------------------------------------------
interface apd_rsp_if;
   import apd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [DIV_W-1:0]     divergence;
   logic [OUT_CNT_W-1:0] match_count;
   logic [OUT_CNT_W-1:0] mismatch_count;
   logic [OUT_CNT_W-1:0] gap_open_count;
   logic [OUT_CNT_W-1:0] unpaired_count;
   logic                 empty_flag;

   modport source (output valid, output divergence, output match_count,
                   output mismatch_count, output gap_open_count,
                   output unpaired_count, output empty_flag, input ready);
   modport sink   (input valid, input divergence, input match_count,
                   input mismatch_count, input gap_open_count,
                   input unpaired_count, input empty_flag, output ready);
endinterface

// ===== rtl/core/apd_ctrl.sv =====
// ---------------------------------------------------------------------------
// apd_ctrl
// Sequencer: column accept, product / sum stages, divider steps, result load.
// ---------------------------------------------------------------------------
module apd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output apd_pkg::apd_cmd_type cmd,
   input  apd_pkg::apd_sts_type sts
);
   import apd_pkg::*;

   localparam logic [2:0] S_RUN = 3'd0;
   localparam logic [2:0] S_MUL = 3'd1;
   localparam logic [2:0] S_SUM = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_OUT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // result register can take a new beat
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_RUN);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_RUN: begin
            if (req_valid) begin
               cmd.col_en = 1'b1;
               if (req_last) state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_RUN;
            end
         end
         default: state_in = S_RUN;
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready)        rsp_valid_in = 1'b0;
      else                       rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/apd_dp.sv =====
// ---------------------------------------------------------------------------
// apd_dp
// Datapath: config registers, column counters, weighted sums, serial divider.
// ---------------------------------------------------------------------------
`include "alignment_pair_divergence_defines.svh"

module apd_dp #(
   parameter int COUNT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [apd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [apd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [apd_pkg::RESIDUE_W-1:0]    residue_a,
   input  logic [apd_pkg::RESIDUE_W-1:0]    residue_b,
   input  apd_pkg::apd_cmd_type             cmd,
   output apd_pkg::apd_sts_type             sts,
   output logic [apd_pkg::DIV_W-1:0]        divergence,
   output logic [apd_pkg::OUT_CNT_W-1:0]    match_count,
   output logic [apd_pkg::OUT_CNT_W-1:0]    mismatch_count,
   output logic [apd_pkg::OUT_CNT_W-1:0]    gap_open_count,
   output logic [apd_pkg::OUT_CNT_W-1:0]    unpaired_count,
   output logic                             empty_flag
);
   import apd_pkg::*;

   localparam int PROD_W = COUNT_BITS + 9;
   localparam int DEN_W  = COUNT_BITS + 10;
   localparam int REM_W  = COUNT_BITS + 11;
   localparam int EXT_W  = COUNT_BITS + OUT_CNT_W;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [OUT_CNT_W-1:0] out_sat(input logic [COUNT_BITS-1:0] v);
      logic [EXT_W-1:0] ext;
      ext = {{OUT_CNT_W{1'b0}}, v};
      return (|ext[EXT_W-1:OUT_CNT_W]) ? {OUT_CNT_W{1'b1}} : ext[OUT_CNT_W-1:0];
   endfunction

   // config
   logic [RESIDUE_W-1:0] gap_symbol_ff;
   logic [WEIGHT_W-1:0]  gap_weight_ff;

   // running state
   logic [COUNT_BITS-1:0] matches_ff, matches_in;
   logic [COUNT_BITS-1:0] mismatches_ff, mismatches_in;
   logic [COUNT_BITS-1:0] gap_opens_ff, gap_opens_in;
   logic [COUNT_BITS-1:0] unpaired_ff, unpaired_in;
   logic [COUNT_BITS-1:0] run_a_ff, run_a_in;
   logic [COUNT_BITS-1:0] run_b_ff, run_b_in;

   // final computation
   logic [WEIGHT_W-1:0] weight_eff, weight_cmp;
   logic [PROD_W-1:0]   prod_g_ff, prod_u_ff;
   logic [DEN_W-1:0]    diff_sum, den_sum;
   logic [DEN_W-1:0]    den_ff;
   logic [REM_W-1:0]    rem_ff, rem_in, trial;
   logic                trial_ge;
   logic [DIV_W-1:0]    quot_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                empty_ff;

   // result register
   logic [DIV_W-1:0]     div_out_ff;
   logic [OUT_CNT_W-1:0] mch_out_ff, mmc_out_ff, gap_out_ff, unp_out_ff;
   logic                 empty_out_ff;

   logic gap_a, gap_b;

   assign gap_a = (residue_a == gap_symbol_ff);
   assign gap_b = (residue_b == gap_symbol_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_symbol_ff <= GAP_SYMBOL_RST;
         gap_weight_ff <= GAP_WEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GAP_SYMBOL: gap_symbol_ff <= csr_wdata[RESIDUE_W-1:0];
            REG_GAP_WEIGHT: gap_weight_ff <= csr_wdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // column rules; a both-gap column only extends run A
   always_comb begin
      matches_in    = matches_ff;
      mismatches_in = mismatches_ff;
      gap_opens_in  = gap_opens_ff;
      unpaired_in   = unpaired_ff;
      run_a_in      = run_a_ff;
      run_b_in      = run_b_ff;
      if (cmd.out_load) begin
         matches_in    = '0;
         mismatches_in = '0;
         gap_opens_in  = '0;
         unpaired_in   = '0;
         run_a_in      = '0;
         run_b_in      = '0;
      end else if (cmd.col_en) begin
         if (gap_a) begin
            if (!gap_b) begin
               unpaired_in = sat_inc(unpaired_ff);
               if (run_a_ff <= run_b_ff) gap_opens_in = sat_inc(gap_opens_ff);
               run_b_in = '0;
            end
            run_a_in = sat_inc(run_a_ff);
         end else begin
            if (gap_b) begin
               unpaired_in = sat_inc(unpaired_ff);
               if (run_a_ff >= run_b_ff) gap_opens_in = sat_inc(gap_opens_ff);
               run_b_in = sat_inc(run_b_ff);
            end else begin
               if (residue_a == residue_b) matches_in = sat_inc(matches_ff);
               else                        mismatches_in = sat_inc(mismatches_ff);
               run_b_in = '0;
            end
            run_a_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matches_ff    <= '0;
         mismatches_ff <= '0;
         gap_opens_ff  <= '0;
         unpaired_ff   <= '0;
         run_a_ff      <= '0;
         run_b_ff      <= '0;
      end else begin
         matches_ff    <= matches_in;
         mismatches_ff <= mismatches_in;
         gap_opens_ff  <= gap_opens_in;
         unpaired_ff   <= unpaired_in;
         run_a_ff      <= run_a_in;
         run_b_ff      <= run_b_in;
      end
   end

   // weight above one is clamped to one
   assign weight_eff = (gap_weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : gap_weight_ff;
   assign weight_cmp = WEIGHT_ONE - weight_eff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_g_ff <= PROD_W'(weight_eff) * PROD_W'(gap_opens_ff);
         prod_u_ff <= PROD_W'(weight_cmp) * PROD_W'(unpaired_ff);
      end
   end

   assign diff_sum = DEN_W'(prod_g_ff) + DEN_W'(prod_u_ff)
                   + DEN_W'({mismatches_ff, 8'd0});
   assign den_sum  = DEN_W'(prod_g_ff) + DEN_W'(prod_u_ff)
                   + DEN_W'({mismatches_ff, 8'd0}) + DEN_W'({matches_ff, 8'd0});

   // restoring divider: first step compares without shifting, since diff <= den
   assign trial    = (step_ff == '0) ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
   assign trial_ge = (trial >= REM_W'(den_ff));
   assign rem_in   = trial_ge ? trial - REM_W'(den_ff) : trial;

   assign sts.div_last = (step_ff == STEP_W'(QUOT_STEPS - 1));

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         den_ff   <= den_sum;
         rem_ff   <= REM_W'(diff_sum);
         quot_ff  <= '0;
         step_ff  <= '0;
         empty_ff <= (den_sum == '0);
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[DIV_W-2:0], trial_ge};
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         div_out_ff   <= empty_ff ? '0 : quot_ff;
         empty_out_ff <= empty_ff;
         mch_out_ff   <= out_sat(matches_ff);
         mmc_out_ff   <= out_sat(mismatches_ff);
         gap_out_ff   <= out_sat(gap_opens_ff);
         unp_out_ff   <= out_sat(unpaired_ff);
      end
   end

   assign divergence     = div_out_ff;
   assign match_count    = mch_out_ff;
   assign mismatch_count = mmc_out_ff;
   assign gap_open_count = gap_out_ff;
   assign unpaired_count = unp_out_ff;
   assign empty_flag     = empty_out_ff;

   `APD_ASSERT_NXT(a_num_le_den, clock, reset, cmd.sum_en, rem_ff <= REM_W'(den_ff), "numerator exceeds denominator")
   `APD_ASSERT_IMP(a_rem_below_den, clock, reset, cmd.div_step && step_ff != '0 && den_ff != '0, rem_ff < REM_W'(den_ff), "divider remainder out of range")
   `APD_ASSERT_IMP(a_quot_range, clock, reset, cmd.out_load && !empty_ff, quot_ff <= DIV_MAX, "divergence above one")
   `APD_ASSERT_NXT(a_state_cleared, clock, reset, cmd.out_load, matches_ff == '0 && mismatches_ff == '0 && gap_opens_ff == '0 && unpaired_ff == '0 && run_a_ff == '0 && run_b_ff == '0, "running state not cleared after result")

endmodule

// ===== rtl/core/alignment_pair_divergence.sv =====
// ---------------------------------------------------------------------------
// alignment_pair_divergence
// Pairwise alignment divergence with weighted gap openings, top level.
// ---------------------------------------------------------------------------
// Takes one alignment column per beat and keeps match, mismatch, unpaired
// and gap-opening counts (saturating). Columns are accepted one per cycle.
// The beat flagged last_column closes the alignment: the block then takes
// no column until it has run one product stage, one sum stage, 17 steps
// of the bit-serial divider that forms the Q1.16 divergence, and one
// result load. The result sits in an output register, so a new alignment
// streams in while the previous result waits; the load stalls only if a
// result is still pending when the next one is done. The user must write
// gap_symbol and gap_weight through the csr port only while no alignment
// is in flight; the block itself does not enforce this.
module alignment_pair_divergence #(
   parameter int COUNT_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [apd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [apd_pkg::CSR_DATA_W-1:0] csr_wdata,
   apd_req_if.sink                        req_chan,
   apd_rsp_if.source                      rsp_chan
);
   import apd_pkg::*;

   apd_cmd_type cmd;
   apd_sts_type sts;
   logic        req_ready;
   logic        rsp_valid;

   apd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_column),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   apd_dp #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .residue_a      (req_chan.residue_a),
      .residue_b      (req_chan.residue_b),
      .cmd            (cmd),
      .sts            (sts),
      .divergence     (rsp_chan.divergence),
      .match_count    (rsp_chan.match_count),
      .mismatch_count (rsp_chan.mismatch_count),
      .gap_open_count (rsp_chan.gap_open_count),
      .unpaired_count (rsp_chan.unpaired_count),
      .empty_flag     (rsp_chan.empty_flag)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule
